### rtl/core/prle_pkg.sv
package prle_pkg;

   // field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CNT_W    = 13;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned REP_W    = 16;
   localparam int unsigned LIT_W    = 8;
   localparam int unsigned MASK_W   = 4;
   localparam int unsigned PIDX_W   = 2;
   localparam int unsigned PCNT_W   = 3;
   localparam int unsigned PMASKS_W = 16;
   localparam int unsigned KINDS_W  = 4;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;

   // largest value a 13-bit bound register can hold
   localparam int unsigned CNT_MAX  = 8191;

   // count byte codes
   localparam logic [BYTE_W-1:0] CODE_LONG_REPEAT = 8'd128;
   localparam logic [BYTE_W-1:0] CODE_REPEAT_BIAS = 8'd127;

   // register indexes
   typedef enum logic [2:0] {
      REG_LINE_WIDTH   = 3'd0,
      REG_LINE_COUNT   = 3'd1,
      REG_PACKET_COUNT = 3'd2,
      REG_PACKET_MASKS = 3'd3,
      REG_PACKET_KINDS = 3'd4,
      REG_KEEP_ALPHA   = 3'd5
   } reg_index_type;

   // register reset values
   localparam logic [CNT_W-1:0]    RST_LINE_WIDTH   = 13'd1;
   localparam logic [CNT_W-1:0]    RST_LINE_COUNT   = 13'd1;
   localparam logic [PCNT_W-1:0]   RST_PACKET_COUNT = 3'd1;
   localparam logic [PMASKS_W-1:0] RST_PACKET_MASKS = 16'h1111;
   localparam logic [KINDS_W-1:0]  RST_PACKET_KINDS = 4'h0;
   localparam logic                RST_KEEP_ALPHA   = 1'b1;

   // decode phase, one-hot
   typedef enum logic [5:0] {
      PH_COUNT   = 6'b000001,
      PH_HI      = 6'b000010,
      PH_LO      = 6'b000100,
      PH_LITERAL = 6'b001000,
      PH_REPEAT  = 6'b010000,
      PH_RAW     = 6'b100000
   } phase_type;

endpackage

### rtl/core/pic_mixed_rle_decoder_core.sv
// Mixed run-length pixel stream decoder.
// Input channel (req_*): one byte of the compressed pixel stream per beat.
// Result channel (rsp_*): one run descriptor (row, start column, length,
// channel values, lane mask, packet index, overrun and image end flags).
// A byte yields zero or one run: count bytes, repeat count bytes and the
// inner bytes of a multi-lane pixel give none.
// The run of a byte is registered: it is on the result port right after
// the edge that accepts the byte.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the single decode step between the state registers and the result
// register. A new byte is taken while a run is held as long as that run is
// taken in the same cycle; when the receiver stalls, the run holds in the
// result register and req_ready drops until it is taken.
// Configuration goes through an APB-style port, register i at byte 4*i;
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (synchronous) loads the register reset values, clears all decode
// state to the start of an image and empties the result register.
module pic_mixed_rle_decoder_core #(
   parameter int MAX_WIDTH   = 4096,
   parameter int MAX_HEIGHT  = 4096,
   parameter int MAX_PACKETS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [prle_pkg::ADDR_W-1:0]       paddr,
   input  logic [prle_pkg::DATA_W-1:0]       pwdata,
   output logic [prle_pkg::DATA_W-1:0]       prdata,
   output logic                              pready,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [prle_pkg::BYTE_W-1:0]       req_data_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [prle_pkg::POS_W-1:0]        rsp_row,
   output logic [prle_pkg::POS_W-1:0]        rsp_start_x,
   output logic [prle_pkg::CNT_W-1:0]        rsp_run_length,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_red,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_green,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_blue,
   output logic [prle_pkg::BYTE_W-1:0]       rsp_alpha,
   output logic [prle_pkg::MASK_W-1:0]       rsp_lane_mask,
   output logic [prle_pkg::PIDX_W-1:0]       rsp_packet_index,
   output logic                              rsp_overrun,
   output logic                              rsp_image_done
);
   import prle_pkg::*;

   // saturation limits
   localparam int W_LIM_I = (MAX_WIDTH  > CNT_MAX) ? CNT_MAX : MAX_WIDTH;
   localparam int H_LIM_I = (MAX_HEIGHT > CNT_MAX) ? CNT_MAX : MAX_HEIGHT;
   localparam logic [CNT_W-1:0]  W_LIM = CNT_W'(W_LIM_I);
   localparam logic [CNT_W-1:0]  H_LIM = CNT_W'(H_LIM_I);
   localparam logic [PCNT_W-1:0] P_LIM = PCNT_W'(MAX_PACKETS);

   // configuration registers
   logic [CNT_W-1:0]    line_width_ff;
   logic [CNT_W-1:0]    line_count_ff;
   logic [PCNT_W-1:0]   packet_count_ff;
   logic [PMASKS_W-1:0] packet_masks_ff;
   logic [KINDS_W-1:0]  packet_kinds_ff;
   logic                keep_alpha_ff;

   // decode state
   logic [CNT_W-1:0]    row_ff,   row_in;
   logic [CNT_W-1:0]    col_ff,   col_in;
   logic [PIDX_W-1:0]   pp_ff,    pp_in;
   phase_type           ph_ff,    ph_in;
   logic [REP_W-1:0]    rep_ff,   rep_in;
   logic [LIT_W-1:0]    lit_ff,   lit_in;
   logic [PIDX_W-1:0]   slot_ff,  slot_in;
   logic [4*BYTE_W-1:0] gath_ff,  gath_in;

   // result register
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    row_out_ff,   row_out_in;
   logic [POS_W-1:0]    x_out_ff,     x_out_in;
   logic [CNT_W-1:0]    len_out_ff,   len_out_in;
   logic [4*BYTE_W-1:0] vals_out_ff,  vals_out_in;
   logic [MASK_W-1:0]   lanes_out_ff, lanes_out_in;
   logic [PIDX_W-1:0]   pidx_out_ff,  pidx_out_in;
   logic                over_out_ff,  over_out_in;
   logic                done_out_ff,  done_out_in;
   logic                emit_in;

   logic                    req_accept;
   logic                    csr_write;
   reg_index_type           csr_index;
   logic [CNT_W-1:0]        w_eff;
   logic [CNT_W-1:0]        h_eff;
   logic [PCNT_W-1:0]       np_eff;

   assign pready     = 1'b1;
   assign csr_write  = psel & penable & pwrite;
   assign csr_index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   // clamp the bounds
   assign w_eff  = (line_width_ff == '0) ? CNT_W'(1) :
                   (line_width_ff > W_LIM) ? W_LIM : line_width_ff;
   assign h_eff  = (line_count_ff == '0) ? CNT_W'(1) :
                   (line_count_ff > H_LIM) ? H_LIM : line_count_ff;
   assign np_eff = (packet_count_ff == '0) ? PCNT_W'(1) :
                   (packet_count_ff > P_LIM) ? P_LIM : packet_count_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= RST_LINE_WIDTH;
         line_count_ff   <= RST_LINE_COUNT;
         packet_count_ff <= RST_PACKET_COUNT;
         packet_masks_ff <= RST_PACKET_MASKS;
         packet_kinds_ff <= RST_PACKET_KINDS;
         keep_alpha_ff   <= RST_KEEP_ALPHA;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LINE_WIDTH:   line_width_ff   <= pwdata[CNT_W-1:0];
            REG_LINE_COUNT:   line_count_ff   <= pwdata[CNT_W-1:0];
            REG_PACKET_COUNT: packet_count_ff <= pwdata[PCNT_W-1:0];
            REG_PACKET_MASKS: packet_masks_ff <= pwdata[PMASKS_W-1:0];
            REG_PACKET_KINDS: packet_kinds_ff <= pwdata[KINDS_W-1:0];
            REG_KEEP_ALPHA:   keep_alpha_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_LINE_WIDTH:   prdata = DATA_W'(line_width_ff);
         REG_LINE_COUNT:   prdata = DATA_W'(line_count_ff);
         REG_PACKET_COUNT: prdata = DATA_W'(packet_count_ff);
         REG_PACKET_MASKS: prdata = DATA_W'(packet_masks_ff);
         REG_PACKET_KINDS: prdata = DATA_W'(packet_kinds_ff);
         REG_KEEP_ALPHA:   prdata = DATA_W'(keep_alpha_ff);
         default:          prdata = '0;
      endcase
   end

   // decode step for one byte
   always_comb begin
      logic                bad;
      logic                ph_ok;
      logic [CNT_W-1:0]    row_c;
      logic [CNT_W-1:0]    col_c;
      logic [PIDX_W-1:0]   pp_c;
      phase_type           ph_c;
      logic [REP_W-1:0]    rep_c;
      logic [LIT_W-1:0]    lit_c;
      logic [PIDX_W-1:0]   slot_c;
      logic [4*BYTE_W-1:0] gath_c;
      logic [MASK_W-1:0]   mask;
      logic                mixed;
      logic [2:0]          n;
      logic [2:0]          k;
      logic [4*BYTE_W-1:0] gath_t;
      logic                done;
      logic [PIDX_W-1:0]   slot_t;
      logic                do_end;
      logic [CNT_W-1:0]    len;
      logic [CNT_W-1:0]    rem;
      logic                over;
      logic [CNT_W-1:0]    col_next;
      logic [LIT_W-1:0]    lit_dec;
      logic [BYTE_W-1:0]   b;

      b = req_data_byte;

      // restart at image start when state no longer fits the bounds
      ph_ok = (ph_ff == PH_COUNT) || (ph_ff == PH_HI) || (ph_ff == PH_LO) ||
              (ph_ff == PH_LITERAL) || (ph_ff == PH_REPEAT) || (ph_ff == PH_RAW);
      bad = (row_ff >= h_eff) || ({1'b0, pp_ff} >= np_eff) || !ph_ok ||
            (col_ff > w_eff) || ((col_ff == w_eff) && (ph_ff != PH_LITERAL));
      row_c  = bad ? '0 : row_ff;
      col_c  = bad ? '0 : col_ff;
      pp_c   = bad ? '0 : pp_ff;
      ph_c   = bad ? PH_COUNT : ph_ff;
      rep_c  = bad ? '0 : rep_ff;
      lit_c  = bad ? '0 : lit_ff;
      slot_c = bad ? '0 : slot_ff;
      gath_c = bad ? '0 : gath_ff;

      mask  = packet_masks_ff[{pp_c, 2'b00} +: MASK_W];
      mixed = packet_kinds_ff[pp_c];

      // place the byte in its lane of the current pixel
      n = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
      if (n == 3'd0) begin
         n = 3'd1;
      end
      gath_t = gath_c;
      k = 3'd0;
      for (int l = 0; l < MASK_W; l++) begin
         if (mask[l]) begin
            if (k == {1'b0, slot_c}) begin
               gath_t[BYTE_W*l +: BYTE_W] = gath_c[BYTE_W*l +: BYTE_W] | b;
            end
            k = k + 3'd1;
         end
      end
      done   = (3'({1'b0, slot_c}) + 3'd1) >= n;
      slot_t = done ? '0 : slot_c + PIDX_W'(1);

      col_next = col_c + CNT_W'(1);
      lit_dec  = (lit_c != '0) ? lit_c - LIT_W'(1) : lit_c;
      rem      = w_eff - col_c;

      // defaults: state carries over
      row_in  = row_c;
      col_in  = col_c;
      pp_in   = pp_c;
      ph_in   = ph_c;
      rep_in  = rep_c;
      lit_in  = lit_c;
      slot_in = slot_c;
      gath_in = gath_c;
      emit_in = 1'b0;
      len     = CNT_W'(1);
      over    = 1'b0;
      do_end  = 1'b0;

      unique case (ph_c)
         PH_COUNT: begin
            if (mixed) begin
               if (b < CODE_LONG_REPEAT) begin
                  lit_in = b + LIT_W'(1);
                  ph_in  = PH_LITERAL;
               end else if (b == CODE_LONG_REPEAT) begin
                  ph_in = PH_HI;
               end else begin
                  rep_in = REP_W'(b - CODE_REPEAT_BIAS);
                  ph_in  = PH_REPEAT;
               end
            end else begin
               slot_in = slot_t;
               gath_in = gath_t;
               if (!done) begin
                  ph_in = PH_RAW;
               end else begin
                  emit_in = 1'b1;
                  col_in  = col_next;
                  do_end  = col_next >= w_eff;
               end
            end
         end
         PH_RAW: begin
            slot_in = slot_t;
            gath_in = gath_t;
            if (done) begin
               emit_in = 1'b1;
               col_in  = col_next;
               ph_in   = PH_COUNT;
               do_end  = col_next >= w_eff;
            end
         end
         PH_HI: begin
            rep_in = {b, 8'h00};
            ph_in  = PH_LO;
         end
         PH_LO: begin
            rep_in = rep_c | REP_W'(b);
            ph_in  = ((rep_c | REP_W'(b)) == '0) ? PH_COUNT : PH_REPEAT;
         end
         PH_LITERAL: begin
            slot_in = slot_t;
            gath_in = gath_t;
            if (done) begin
               lit_in = lit_dec;
               if (col_c >= w_eff) begin
                  // excess pixel past the row end is dropped
                  gath_in = '0;
                  do_end  = lit_dec == '0;
               end else begin
                  emit_in = 1'b1;
                  over    = (lit_c > LIT_W'(1)) && (col_next == w_eff);
                  col_in  = col_next;
                  if (lit_dec == '0) begin
                     ph_in  = PH_COUNT;
                     do_end = col_next >= w_eff;
                  end
               end
            end
         end
         PH_REPEAT: begin
            slot_in = slot_t;
            gath_in = gath_t;
            if (done) begin
               emit_in = 1'b1;
               over    = rep_c > REP_W'(rem);
               len     = over ? rem : rep_c[CNT_W-1:0];
               col_in  = col_c + len;
               ph_in   = PH_COUNT;
               do_end  = (col_c + len) >= w_eff;
            end
         end
         default: ;
      endcase

      // run descriptor from the state before the byte
      row_out_in   = row_c[POS_W-1:0];
      x_out_in     = col_c[POS_W-1:0];
      len_out_in   = len;
      lanes_out_in = mask & (keep_alpha_ff ? 4'b1111 : 4'b0111);
      for (int l = 0; l < MASK_W; l++) begin
         vals_out_in[BYTE_W*l +: BYTE_W] = lanes_out_in[l] ? gath_t[BYTE_W*l +: BYTE_W] : '0;
      end
      pidx_out_in = pp_c;
      over_out_in = over;
      done_out_in = ((CNT_W+1)'(col_c) + (CNT_W+1)'(len) == (CNT_W+1)'(w_eff)) &&
                    ((PCNT_W'(pp_c) + PCNT_W'(1)) == np_eff) &&
                    ((row_c + CNT_W'(1)) == h_eff);
      if (emit_in) begin
         gath_in = '0;
      end

      // packet end: next packet, wrap to next row and image
      if (do_end) begin
         col_in = '0;
         ph_in  = PH_COUNT;
         if ((PCNT_W'(pp_c) + PCNT_W'(1)) >= np_eff) begin
            pp_in  = '0;
            row_in = ((row_c + CNT_W'(1)) >= h_eff) ? '0 : row_c + CNT_W'(1);
         end else begin
            pp_in = pp_c + PIDX_W'(1);
         end
      end
   end

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         pp_ff   <= '0;
         ph_ff   <= PH_COUNT;
         rep_ff  <= '0;
         lit_ff  <= '0;
         slot_ff <= '0;
         gath_ff <= '0;
      end else if (req_accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         pp_ff   <= pp_in;
         ph_ff   <= ph_in;
         rep_ff  <= rep_in;
         lit_ff  <= lit_in;
         slot_ff <= slot_in;
         gath_ff <= gath_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept && emit_in) begin
         row_out_ff   <= row_out_in;
         x_out_ff     <= x_out_in;
         len_out_ff   <= len_out_in;
         vals_out_ff  <= vals_out_in;
         lanes_out_ff <= lanes_out_in;
         pidx_out_ff  <= pidx_out_in;
         over_out_ff  <= over_out_in;
         done_out_ff  <= done_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row          = row_out_ff;
   assign rsp_start_x      = x_out_ff;
   assign rsp_run_length   = len_out_ff;
   assign rsp_red          = vals_out_ff[BYTE_W*0 +: BYTE_W];
   assign rsp_green        = vals_out_ff[BYTE_W*1 +: BYTE_W];
   assign rsp_blue         = vals_out_ff[BYTE_W*2 +: BYTE_W];
   assign rsp_alpha        = vals_out_ff[BYTE_W*3 +: BYTE_W];
   assign rsp_lane_mask    = lanes_out_ff;
   assign rsp_packet_index = pidx_out_ff;
   assign rsp_overrun      = over_out_ff;
   assign rsp_image_done   = done_out_ff;

endmodule

### tb/sv/prle_run_checker.sv
module prle_run_checker #(
   parameter int MAX_WIDTH   = 4096,
   parameter int MAX_HEIGHT  = 4096,
   parameter int MAX_PACKETS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [prle_pkg::ADDR_W-1:0]   paddr,
   input  logic [prle_pkg::DATA_W-1:0]   pwdata,
   input  logic                          pready,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [prle_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [prle_pkg::POS_W-1:0]    rsp_row,
   input  logic [prle_pkg::POS_W-1:0]    rsp_start_x,
   input  logic [prle_pkg::CNT_W-1:0]    rsp_run_length,
   input  logic [prle_pkg::BYTE_W-1:0]   rsp_red,
   input  logic [prle_pkg::BYTE_W-1:0]   rsp_green,
   input  logic [prle_pkg::BYTE_W-1:0]   rsp_blue,
   input  logic [prle_pkg::BYTE_W-1:0]   rsp_alpha,
   input  logic [prle_pkg::MASK_W-1:0]   rsp_lane_mask,
   input  logic [prle_pkg::PIDX_W-1:0]   rsp_packet_index,
   input  logic                          rsp_overrun,
   input  logic                          rsp_image_done,
   output int                            bad_runs,
   output int                            runs_in_flight
);
   import prle_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  start_x;
      logic [CNT_W-1:0]  run_length;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
      logic [MASK_W-1:0] lane_mask;
      logic [PIDX_W-1:0] packet_index;
      logic              overrun;
      logic              image_done;
   } run_desc_type;

   run_desc_type predicted_runs[$];
   int           reports;

   // shadow of the configuration registers
   logic [CNT_W-1:0]    cfg_width;
   logic [CNT_W-1:0]    cfg_height;
   logic [PCNT_W-1:0]   cfg_packets;
   logic [PMASKS_W-1:0] cfg_masks;
   logic [KINDS_W-1:0]  cfg_kinds;
   logic                cfg_keep_alpha;

   // shadow of the decode state
   logic [POS_W-1:0]  row_q;
   logic [CNT_W-1:0]  col_q;
   logic [PIDX_W-1:0] pkt_q;
   phase_type         phase_q;
   logic [REP_W-1:0]  repeat_q;
   logic [LIT_W-1:0]  lit_q;
   logic [1:0]        slot_q;
   logic [31:0]       pix_q;

   function automatic int unsigned clamp_bound(int unsigned v, int unsigned ceiling);
      if (v == 0) return 1;
      if (v > ceiling) return ceiling;
      return v;
   endfunction

   function automatic string run_text(run_desc_type r);
      return $sformatf({"row %0d x %0d len %0d rgba %h %h %h %h",
                        " lanes %h pkt %0d ovr %0d done %0d"},
                       r.row, r.start_x, r.run_length, r.red, r.green, r.blue, r.alpha,
                       r.lane_mask, r.packet_index, r.overrun, r.image_done);
   endfunction

   task automatic clear_decode();
      row_q    = '0;
      col_q    = '0;
      pkt_q    = '0;
      phase_q  = PH_COUNT;
      repeat_q = '0;
      lit_q    = '0;
      slot_q   = '0;
      pix_q    = '0;
   endtask

   // place one byte in the pixel being gathered, 1 when the pixel is complete
   function automatic bit gather_byte(logic [MASK_W-1:0] mask, logic [BYTE_W-1:0] b);
      int n;
      int k;
      int l;
      bit done;
      n = $countones(mask);
      if (n == 0) n = 1;
      k = 0;
      for (l = 0; l < 4; l++) begin
         if (mask[l]) begin
            if (k == int'(slot_q)) pix_q[8*l +: 8] = pix_q[8*l +: 8] | b;
            k++;
         end
      end
      done = (int'(slot_q) + 1 >= n);
      slot_q = done ? 2'd0 : slot_q + 2'd1;
      return done;
   endfunction

   task automatic push_run(logic [MASK_W-1:0] mask, int unsigned len, bit over,
                           int unsigned w, int unsigned h, int unsigned np);
      run_desc_type      r;
      logic [MASK_W-1:0] lanes;
      lanes          = mask & (cfg_keep_alpha ? 4'hF : 4'h7);
      r.row          = row_q;
      r.start_x      = col_q[POS_W-1:0];
      r.run_length   = CNT_W'(len);
      r.red          = lanes[0] ? pix_q[7:0]   : 8'h00;
      r.green        = lanes[1] ? pix_q[15:8]  : 8'h00;
      r.blue         = lanes[2] ? pix_q[23:16] : 8'h00;
      r.alpha        = lanes[3] ? pix_q[31:24] : 8'h00;
      r.lane_mask    = lanes;
      r.packet_index = pkt_q;
      r.overrun      = over;
      r.image_done   = (col_q + len == w) && (pkt_q + 1 == np) && (row_q + 1 == h);
      pix_q          = '0;
      predicted_runs.push_back(r);
   endtask

   task automatic close_packet(int unsigned h, int unsigned np);
      col_q   = '0;
      phase_q = PH_COUNT;
      if (pkt_q + 1 >= np) begin
         pkt_q = '0;
         if (row_q + 1 >= h) row_q = '0;
         else row_q = row_q + 1'b1;
      end else begin
         pkt_q = pkt_q + 1'b1;
      end
   endtask

   // advance the decode state by one accepted byte
   task automatic decode_byte(logic [BYTE_W-1:0] b);
      int unsigned       w;
      int unsigned       h;
      int unsigned       np;
      int unsigned       left;
      int unsigned       len;
      logic [MASK_W-1:0] mask;
      bit                mixed;
      w  = clamp_bound(cfg_width, MAX_WIDTH);
      h  = clamp_bound(cfg_height, MAX_HEIGHT);
      np = clamp_bound(cfg_packets, MAX_PACKETS);

      // restart when the state no longer fits the bounds
      if (row_q >= h || pkt_q >= np || col_q > w || (col_q == w && phase_q != PH_LITERAL))
         clear_decode();

      mask  = cfg_masks[4*pkt_q +: 4];
      mixed = cfg_kinds[pkt_q];

      case (phase_q)
         PH_COUNT: begin
            if (mixed) begin
               if (b < CODE_LONG_REPEAT) begin
                  lit_q   = b + 8'd1;
                  phase_q = PH_LITERAL;
               end else if (b == CODE_LONG_REPEAT) begin
                  phase_q = PH_HI;
               end else begin
                  repeat_q = REP_W'(b - CODE_REPEAT_BIAS);
                  phase_q  = PH_REPEAT;
               end
            end else if (!gather_byte(mask, b)) begin
               phase_q = PH_RAW;
            end else begin
               push_run(mask, 1, 1'b0, w, h, np);
               col_q = col_q + 1'b1;
               if (col_q >= w) close_packet(h, np);
            end
         end
         PH_RAW: begin
            if (gather_byte(mask, b)) begin
               push_run(mask, 1, 1'b0, w, h, np);
               col_q   = col_q + 1'b1;
               phase_q = PH_COUNT;
               if (col_q >= w) close_packet(h, np);
            end
         end
         PH_HI: begin
            repeat_q = {b, 8'h00};
            phase_q  = PH_LO;
         end
         PH_LO: begin
            repeat_q[7:0] = b;
            phase_q = (repeat_q == '0) ? PH_COUNT : PH_REPEAT;
         end
         PH_LITERAL: begin
            if (gather_byte(mask, b)) begin
               if (col_q >= w) begin
                  // excess literal past row end, dropped
                  pix_q = '0;
                  if (lit_q > 0) lit_q = lit_q - 1'b1;
                  if (lit_q == 0) close_packet(h, np);
               end else begin
                  push_run(mask, 1, (lit_q > 1) && (col_q + 1 == w), w, h, np);
                  col_q = col_q + 1'b1;
                  if (lit_q > 0) lit_q = lit_q - 1'b1;
                  if (lit_q == 0) begin
                     phase_q = PH_COUNT;
                     if (col_q >= w) close_packet(h, np);
                  end
               end
            end
         end
         PH_REPEAT: begin
            if (gather_byte(mask, b)) begin
               left = w - col_q;
               len  = (repeat_q > left) ? left : repeat_q;
               push_run(mask, len, repeat_q > left, w, h, np);
               col_q   = col_q + CNT_W'(len);
               phase_q = PH_COUNT;
               if (col_q >= w) close_packet(h, np);
            end
         end
         default: ;
      endcase
   endtask

   // watch the ports, compare results and predict at each edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_width      = RST_LINE_WIDTH;
         cfg_height     = RST_LINE_COUNT;
         cfg_packets    = RST_PACKET_COUNT;
         cfg_masks      = RST_PACKET_MASKS;
         cfg_kinds      = RST_PACKET_KINDS;
         cfg_keep_alpha = RST_KEEP_ALPHA;
         clear_decode();
         predicted_runs.delete();
         bad_runs = 0;
         reports  = 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            run_desc_type seen;
            seen = '{rsp_row, rsp_start_x, rsp_run_length, rsp_red, rsp_green, rsp_blue,
                     rsp_alpha, rsp_lane_mask, rsp_packet_index, rsp_overrun, rsp_image_done};
            if (predicted_runs.size() == 0) begin
               bad_runs++;
               if (reports < 10) begin
                  reports++;
                  $display("unexpected run: %s", run_text(seen));
               end
            end else begin
               run_desc_type want;
               want = predicted_runs.pop_front();
               if (seen !== want) begin
                  bad_runs++;
                  if (reports < 10) begin
                     reports++;
                     $display("run mismatch: expected %s", run_text(want));
                     $display("              actual   %s", run_text(seen));
                  end
               end
            end
         end

         // register write
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[ADDR_W-1:2]))
               REG_LINE_WIDTH:   cfg_width      = pwdata[CNT_W-1:0];
               REG_LINE_COUNT:   cfg_height     = pwdata[CNT_W-1:0];
               REG_PACKET_COUNT: cfg_packets    = pwdata[PCNT_W-1:0];
               REG_PACKET_MASKS: cfg_masks      = pwdata[PMASKS_W-1:0];
               REG_PACKET_KINDS: cfg_kinds      = pwdata[KINDS_W-1:0];
               REG_KEEP_ALPHA:   cfg_keep_alpha = pwdata[0];
               default: ;
            endcase
         end

         // stream byte beat
         if (req_valid && req_ready) decode_byte(req_data_byte);
      end
      runs_in_flight = predicted_runs.size();
   end

endmodule

### tb/sv/testbench.sv
module testbench;
   import prle_pkg::*;

   localparam int MAX_W   = 4096;
   localparam int MAX_H   = 4096;
   localparam int MAX_PKT = 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [POS_W-1:0]    rsp_row;
   logic [POS_W-1:0]    rsp_start_x;
   logic [CNT_W-1:0]    rsp_run_length;
   logic [BYTE_W-1:0]   rsp_red;
   logic [BYTE_W-1:0]   rsp_green;
   logic [BYTE_W-1:0]   rsp_blue;
   logic [BYTE_W-1:0]   rsp_alpha;
   logic [MASK_W-1:0]   rsp_lane_mask;
   logic [PIDX_W-1:0]   rsp_packet_index;
   logic                rsp_overrun;
   logic                rsp_image_done;

   int bad_runs;
   int runs_in_flight;
   bit no_idle = 1'b0;
   int stall_left = 0;

   // two rows of two mixed packets: zero repeat, short repeat, literal overrun,
   // long repeat clipped on an empty mask, a clipped repeat, then an exact fit ending the image
   logic [7:0] probe [24] = '{
      8'h80, 8'h00, 8'h00,
      8'h81, 8'hFF, 8'h00, 8'hAA,
      8'h01, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
      8'h80, 8'h01, 8'h00, 8'h77,
      8'hFF, 8'h01, 8'h02, 8'h03,
      8'h82, 8'h00
   };

   always #4 clock = ~clock;

   pic_mixed_rle_decoder_core #(
      .MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .MAX_PACKETS(MAX_PKT)
   ) i_dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row(rsp_row), .rsp_start_x(rsp_start_x), .rsp_run_length(rsp_run_length),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue), .rsp_alpha(rsp_alpha),
      .rsp_lane_mask(rsp_lane_mask), .rsp_packet_index(rsp_packet_index),
      .rsp_overrun(rsp_overrun), .rsp_image_done(rsp_image_done)
   );

   prle_run_checker #(
      .MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H), .MAX_PACKETS(MAX_PKT)
   ) i_checker (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row(rsp_row), .rsp_start_x(rsp_start_x), .rsp_run_length(rsp_run_length),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue), .rsp_alpha(rsp_alpha),
      .rsp_lane_mask(rsp_lane_mask), .rsp_packet_index(rsp_packet_index),
      .rsp_overrun(rsp_overrun), .rsp_image_done(rsp_image_done),
      .bad_runs(bad_runs), .runs_in_flight(runs_in_flight)
   );

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // stream byte biased toward short literals, short repeats and long repeat codes
   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return 8'($urandom_range(0, 3));
      if (r < 55) return 8'($urandom_range(129, 135));
      if (r < 60) return CODE_LONG_REPEAT;
      return 8'($urandom_range(0, 255));
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let every predicted run come out
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (runs_in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_image_setup(input int lw, input int lc, input int pc,
                                   input int pm, input int pk, input int ka);
      csr_write(REG_LINE_WIDTH,   DATA_W'(lw));
      csr_write(REG_LINE_COUNT,   DATA_W'(lc));
      csr_write(REG_PACKET_COUNT, DATA_W'(pc));
      csr_write(REG_PACKET_MASKS, DATA_W'(pm));
      csr_write(REG_PACKET_KINDS, DATA_W'(pk));
      csr_write(REG_KEEP_ALPHA,   DATA_W'(ka));
   endtask

   // stimulus
   initial begin
      int ph;
      int i;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setup: one-pixel image, raw red
      send_byte(8'h00);
      send_byte(8'hFF);
      drain();

      // directed mixed packets with alpha dropped and an empty mask
      load_image_setup(3, 2, 2, 16'h000B, 4'h3, 0);
      for (i = 0; i < 24; i++) send_byte(probe[i]);

      // random phases, the first ones at the register extremes
      for (ph = 0; ph < 12; ph++) begin
         drain();
         no_idle <= (ph == 5 || ph == 9);
         case (ph)
            0: load_image_setup(0, 0, 0, $urandom_range(0, 65535), $urandom_range(0, 15), 1);
            1: load_image_setup(CNT_MAX, 1, 1, $urandom_range(0, 65535), 4'hF, 0);
            2: load_image_setup(4096, CNT_MAX, 7, 16'hFFFF, 4'hF, 1);
            3: load_image_setup(2, 2, 4, 16'h0000, 4'h0, 0);
            4: load_image_setup(1, 4096, 4, 16'hFFFF, 4'h5, 1);
            default: load_image_setup($urandom_range(1, 8), $urandom_range(1, 3),
                                      $urandom_range(1, 4), $urandom_range(0, 65535),
                                      $urandom_range(0, 15), $urandom_range(0, 1));
         endcase
         for (i = 0; i < 68; i++) begin
            if (i == 34 && ph % 2 == 1) drain();
            send_byte(pick_byte());
         end
      end

      drain();
      if (bad_runs == 0 && runs_in_flight == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
